[sv/assert_macros.svh]
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define FFA_ASSERT_IMPL(lbl, ante, cons)
`define FFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/ffa_pkg.sv]
// Shared types and constants of the first-fit free-list allocator.
`default_nettype none
package ffa_pkg;
    // Defaults of the top-level parameters.
    localparam int DEF_POOL_DEPTH = 4096;
    localparam int DEF_UNIT_BYTES = 8;

    // Widths of the fixed item fields.
    localparam int REQ_W   = 15;
    localparam int INDEX_W = 12;
    localparam int GRANT_W = 13;
    localparam int CFG_W   = 13;

    // Widths wide enough for any legal parameter value.
    localparam int CMD_BLK_W  = 16;
    localparam int CMD_NEED_W = 14;
    localparam int MAX_PU_W   = 17;

    // Command and status codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Classified command as it travels from front to back.
    typedef struct packed {
        logic                  is_free;
        logic                  bad;
        logic [CMD_NEED_W-1:0] need;
        logic [CMD_BLK_W-1:0]  blk;
    } ffa_cmd_t;

    // Status the back part reports to the front part.
    typedef struct packed {
        logic                clearing;
        logic [MAX_PU_W-1:0] pool_units;
    } ffa_status_t;
endpackage
`default_nettype wire

[sv/first_fit_free_list_allocator_top.sv]
// Top level of the first-fit free-list allocator.
// The block keeps a pool of header-sized units as a circular, address-ordered
// free list. Commands arrive on the s_ channel: tuser[0] = 0 allocates
// request_bytes, tuser[0] = 1 frees the block at block_index. Each command
// gives exactly one result item on the m_ channel: tuser[0] is the status,
// tdata carries the payload index and the granted units.
// An allocate reads the remembered position, then visits one free block per
// cycle on the walk, with a further step when the block is split; a free
// passes one block per cycle while searching the insertion point, then reads
// and writes the headers, and goes straight to the result when it is ignored
// or lands in an empty list. The header memory has a single read port.
// The front part and a two-entry queue take new commands while the back part
// works or while a result waits in the output register.
// After reset, and after every write on the cfg_ channel, the whole header
// memory is swept; s_tready stays low during the sweep.
// A stalled receiver holds the result in the output register; the back part
// then waits with its next finished result and the queue fills.
// The pool size may only be written while no command is in flight.
`default_nettype none
`include "assert_macros.svh"
module first_fit_free_list_allocator_top
    import ffa_pkg::*;
#(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int UNIT_BYTES = DEF_UNIT_BYTES
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,   // pool_units[12:0]
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,    // request_bytes[14:0], block_index[26:15]
    input  wire logic [0:0]       s_tuser,    // command[0]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,    // payload_index[11:0], granted_units[24:12]
    output logic [0:0]            m_tuser     // status[0]
);
    ffa_status_t back_status;
    ffa_cmd_t    push_cmd, q_cmd;
    logic        push_valid, push_ready, q_valid, q_pop;

    ffa_front #(
        .UNIT_BYTES(UNIT_BYTES)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .status    (back_status),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    ffa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_cmd   (push_cmd),
        .out_valid(q_valid),
        .out_pop  (q_pop),
        .out_cmd  (q_cmd)
    );

    ffa_back #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .status   (back_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // No item is taken while the header memory is swept.
    `FFA_ASSERT_IMPL(a_no_accept_in_clear, back_status.clearing, !s_tready)
    // A failed allocate reports zero index and zero units.
    `FFA_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tuser[0] == STATUS_FAIL), m_tdata == '0)
    // A pool size write always starts a sweep.
    `FFA_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, back_status.clearing)
endmodule
`default_nettype wire

[sv/ffa_front.sv]
// Front part: accepts input items and classifies them into commands.
`default_nettype none
module ffa_front
    import ffa_pkg::*;
#(
    parameter int UNIT_BYTES = DEF_UNIT_BYTES
) (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // request_bytes[14:0], block_index[26:15], zeros
    input  wire logic [0:0]  s_tuser,   // command[0]
    input  wire ffa_status_t status,
    output logic             push_valid,
    input  wire logic        push_ready,
    output ffa_cmd_t         push_cmd
);
    // Reciprocal of the unit size, exact for every numerator of REQ_W+1 bits.
    localparam int RCP_SH = REQ_W + 7;
    localparam int PROD_W = REQ_W + 1 + RCP_SH + 1;
    localparam logic [RCP_SH:0] RCP_M =
        (RCP_SH+1)'(((64'd1 << RCP_SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

    logic [REQ_W-1:0]   req;
    logic [INDEX_W-1:0] idx;
    logic [REQ_W:0]     req_sum;
    logic [PROD_W-1:0]  prod;
    logic [REQ_W:0]     units;
    logic [INDEX_W:0]   idx_m1;

    assign req = s_tdata[REQ_W-1:0];
    assign idx = s_tdata[REQ_W+INDEX_W-1:REQ_W];

    // Units needed: round the byte count up and add the header unit.
    assign req_sum = {1'b0, req} + (REQ_W+1)'(UNIT_BYTES - 1);
    assign prod    = PROD_W'(req_sum) * PROD_W'(RCP_M);
    assign units   = prod[RCP_SH +: REQ_W+1];

    // Header index of a block to free; index zero wraps and is caught as bad.
    assign idx_m1 = {1'b0, idx} - (INDEX_W+1)'(1);

    always_comb begin
        push_cmd.is_free = (s_tuser[0] == CMD_FREE);
        push_cmd.need    = CMD_NEED_W'(units) + CMD_NEED_W'(1);
        push_cmd.blk     = CMD_BLK_W'(idx_m1[INDEX_W-1:0]);
        push_cmd.bad     = (idx == '0) ||
                           (MAX_PU_W'(idx_m1[INDEX_W-1:0]) >= status.pool_units);
    end

    // No item enters while the header memory is being cleared.
    assign push_valid = s_tvalid && !status.clearing;
    assign s_tready   = push_ready && !status.clearing;
endmodule
`default_nettype wire

[sv/ffa_queue.sv]
// Two-entry command queue between front and back parts.
`default_nettype none
module ffa_queue
    import ffa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ffa_cmd_t in_cmd,
    output logic          out_valid,
    input  wire logic     out_pop,
    output ffa_cmd_t      out_cmd
);
    ffa_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

[sv/ffa_back.sv]
// Back part: header memory, list walking sequencer and result register.
`default_nettype none
module ffa_back
    import ffa_pkg::*;
#(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire ffa_cmd_t         q_cmd,
    output ffa_status_t           status,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,
    output logic [0:0]            m_tuser
);
    localparam int IDX_W   = $clog2(POOL_DEPTH);
    localparam int PU_W    = $clog2(POOL_DEPTH + 1);
    localparam int SIZE_W  = PU_W + 1;
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W   = ((SIZE_W > CMD_NEED_W) ? SIZE_W : CMD_NEED_W) + 1;
    localparam int TS_W    = CMP_W + 1;
    localparam int SUM_W   = SIZE_W + 1;
    localparam int CLAMP_W = ((PU_W > CFG_W) ? PU_W : CFG_W) + 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_A_LINK  = 4'd2;
    localparam logic [3:0] S_A_CHECK = 4'd3;
    localparam logic [3:0] S_A_SPLIT = 4'd4;
    localparam logic [3:0] S_F_WALK  = 4'd5;
    localparam logic [3:0] S_F_RB    = 4'd6;
    localparam logic [3:0] S_F_RN    = 4'd7;
    localparam logic [3:0] S_F_RC    = 4'd8;
    localparam logic [3:0] S_F_LO    = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // Header memories, one write and one read port each.
    logic [IDX_W-1:0]  next_mem [POOL_DEPTH];
    logic [SIZE_W-1:0] size_mem [POOL_DEPTH];
    logic              nx_we, sz_we;
    logic [IDX_W-1:0]  nx_wa, sz_wa, nx_wd, rd_addr;
    logic [SIZE_W-1:0] sz_wd;
    logic [IDX_W-1:0]  rd_next_q;
    logic [SIZE_W-1:0] rd_size_q;

    logic [3:0]          state_reg, state_next;
    logic [PU_W-1:0]     pool_reg, pool_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                empty_reg, empty_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic [CMD_NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]    blk_reg, blk_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    curr_reg, curr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    nxt_reg, nxt_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    next_n_reg, next_n_next;
    logic [IDX_W-1:0]    nb_reg, nb_next;
    logic [SIZE_W-1:0]   size_b_reg, size_b_next;
    logic [SIZE_W-1:0]   size_n_reg, size_n_next;
    logic [SIZE_W-1:0]   size_c_reg, size_c_next;
    logic [SIZE_W-1:0]   sb2_reg, sb2_next;
    logic                res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_pay_reg, res_pay_next;
    logic [GRANT_W-1:0]  res_grant_reg, res_grant_next;
    logic                m_status_reg, m_status_next;
    logic [INDEX_W-1:0]  m_pay_reg, m_pay_next;
    logic [GRANT_W-1:0]  m_grant_reg, m_grant_next;

    logic [CLAMP_W-1:0]  cfg_ext;
    logic                fits, exact, found, up, lo;
    logic [TS_W-1:0]     tsum;
    logic [IDX_W-1:0]    tail;
    logic [IDX_W:0]      pay_sum;

    // Memory ports; read data is registered.
    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (sz_we) begin
            size_mem[sz_wa] <= sz_wd;
        end
        rd_next_q <= next_mem[rd_addr];
        rd_size_q <= size_mem[rd_addr];
    end

    // Fit test and split point of the block under the allocate walk.
    assign fits  = CMP_W'(rd_size_q) >= CMP_W'(need_reg);
    assign exact = CMP_W'(rd_size_q) == CMP_W'(need_reg);
    assign tsum  = TS_W'(curr_reg) + TS_W'(need_reg);
    assign tail  = (tsum >= TS_W'(POOL_DEPTH)) ? IDX_W'(tsum - TS_W'(POOL_DEPTH))
                                               : IDX_W'(tsum);
    assign pay_sum = {1'b0, curr_reg} + (IDX_W+1)'(1);

    // Insertion test of the free walk, with the fetched successor.
    assign found = ((blk_reg > curr_reg) && (blk_reg < rd_next_q)) ||
                   ((curr_reg >= rd_next_q) &&
                    ((blk_reg > curr_reg) || (blk_reg < rd_next_q)));

    // Neighbor tests for coalescing.
    assign up = (SUM_W'(blk_reg) + SUM_W'(size_b_reg)) == SUM_W'(nxt_reg);
    assign lo = (SUM_W'(curr_reg) + SUM_W'(size_c_reg)) == SUM_W'(blk_reg);

    assign cfg_ext = CLAMP_W'(cfg_data);

    always_comb begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        pos_next        = pos_reg;
        empty_next      = empty_reg;
        clr_next        = clr_reg;
        m_valid_next    = m_valid_reg;
        need_next       = need_reg;
        blk_next        = blk_reg;
        start_next      = start_reg;
        prev_next       = prev_reg;
        curr_next       = curr_reg;
        cnt_next        = cnt_reg;
        nxt_next        = nxt_reg;
        tail_next       = tail_reg;
        next_n_next     = next_n_reg;
        nb_next         = nb_reg;
        size_b_next     = size_b_reg;
        size_n_next     = size_n_reg;
        size_c_next     = size_c_reg;
        sb2_next        = sb2_reg;
        res_status_next = res_status_reg;
        res_pay_next    = res_pay_reg;
        res_grant_next  = res_grant_reg;
        m_status_next   = m_status_reg;
        m_pay_next      = m_pay_reg;
        m_grant_next    = m_grant_reg;
        nx_we           = 1'b0;
        nx_wa           = '0;
        nx_wd           = '0;
        sz_we           = 1'b0;
        sz_wa           = '0;
        sz_wd           = '0;
        rd_addr         = '0;
        q_pop           = 1'b0;

        // The result register drains independently of the sequencer.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep the header memory back to a single free block.
            S_CLEAR: begin
                nx_we = 1'b1;
                nx_wa = clr_reg;
                sz_we = 1'b1;
                sz_wa = clr_reg;
                sz_wd = (clr_reg == '0) ? SIZE_W'(pool_reg) : '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(POOL_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            // Take the next command and start its walk.
            S_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    need_next       = q_cmd.need;
                    blk_next        = IDX_W'(q_cmd.blk);
                    res_status_next = STATUS_DONE;
                    res_pay_next    = '0;
                    res_grant_next  = '0;
                    if (!q_cmd.is_free) begin
                        if (empty_reg) begin
                            res_status_next = STATUS_FAIL;
                            state_next      = S_DONE;
                        end else begin
                            rd_addr    = pos_reg;
                            start_next = pos_reg;
                            prev_next  = pos_reg;
                            state_next = S_A_LINK;
                        end
                    end else if (q_cmd.bad) begin
                        state_next = S_DONE;
                    end else if (empty_reg) begin
                        nx_we      = 1'b1;
                        nx_wa      = IDX_W'(q_cmd.blk);
                        nx_wd      = IDX_W'(q_cmd.blk);
                        pos_next   = IDX_W'(q_cmd.blk);
                        empty_next = 1'b0;
                        state_next = S_DONE;
                    end else begin
                        rd_addr    = pos_reg;
                        curr_next  = pos_reg;
                        cnt_next   = '0;
                        state_next = S_F_WALK;
                    end
                end
            end
            // First block after the remembered position.
            S_A_LINK: begin
                curr_next  = rd_next_q;
                rd_addr    = rd_next_q;
                cnt_next   = '0;
                state_next = S_A_CHECK;
            end
            // One block visited per cycle.
            S_A_CHECK: begin
                if (fits) begin
                    res_pay_next   = INDEX_W'(pay_sum);
                    res_grant_next = GRANT_W'(need_reg);
                    if (exact) begin
                        if (prev_reg == curr_reg) begin
                            empty_next = 1'b1;
                        end else begin
                            nx_we    = 1'b1;
                            nx_wa    = prev_reg;
                            nx_wd    = rd_next_q;
                            pos_next = prev_reg;
                        end
                        state_next = S_DONE;
                    end else begin
                        nx_we      = 1'b1;
                        nx_wa      = tail;
                        nx_wd      = rd_next_q;
                        sz_we      = 1'b1;
                        sz_wa      = tail;
                        sz_wd      = SIZE_W'(CMP_W'(rd_size_q) - CMP_W'(need_reg));
                        tail_next  = tail;
                        prev_next  = (prev_reg == curr_reg) ? tail : prev_reg;
                        state_next = S_A_SPLIT;
                    end
                end else if ((curr_reg == start_reg) ||
                             (cnt_reg == CNT_W'(POOL_DEPTH))) begin
                    res_status_next = STATUS_FAIL;
                    state_next      = S_DONE;
                end else begin
                    prev_next = curr_reg;
                    curr_next = rd_next_q;
                    rd_addr   = rd_next_q;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            // Shrink the granted front part and link the tail.
            S_A_SPLIT: begin
                sz_we      = 1'b1;
                sz_wa      = curr_reg;
                sz_wd      = SIZE_W'(need_reg);
                nx_we      = 1'b1;
                nx_wa      = prev_reg;
                nx_wd      = tail_reg;
                pos_next   = prev_reg;
                state_next = S_DONE;
            end
            // Find the free block that precedes the one being returned.
            S_F_WALK: begin
                if (found) begin
                    nxt_next   = rd_next_q;
                    rd_addr    = blk_reg;
                    state_next = S_F_RB;
                end else if (cnt_reg == CNT_W'(POOL_DEPTH - 1)) begin
                    state_next = S_DONE;
                end else begin
                    curr_next = rd_next_q;
                    rd_addr   = rd_next_q;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            // Fetch the headers of the block, its successor and predecessor.
            S_F_RB: begin
                size_b_next = rd_size_q;
                rd_addr     = nxt_reg;
                state_next  = S_F_RN;
            end
            S_F_RN: begin
                size_n_next = rd_size_q;
                next_n_next = rd_next_q;
                rd_addr     = curr_reg;
                state_next  = S_F_RC;
            end
            // Write the returned block, merged with its successor if adjacent.
            S_F_RC: begin
                size_c_next = rd_size_q;
                sb2_next    = up ? SIZE_W'(size_b_reg + size_n_reg) : size_b_reg;
                nb_next     = up ? next_n_reg : nxt_reg;
                sz_we       = 1'b1;
                sz_wa       = blk_reg;
                sz_wd       = sb2_next;
                nx_we       = 1'b1;
                nx_wa       = blk_reg;
                if (up && (curr_reg == nxt_reg)) begin
                    nx_wd      = blk_reg;
                    pos_next   = blk_reg;
                    state_next = S_DONE;
                end else begin
                    nx_wd      = nb_next;
                    state_next = S_F_LO;
                end
            end
            // Link or merge the predecessor.
            S_F_LO: begin
                nx_we = 1'b1;
                nx_wa = curr_reg;
                if (lo) begin
                    sz_we = 1'b1;
                    sz_wa = curr_reg;
                    sz_wd = SIZE_W'(size_c_reg + sb2_reg);
                    nx_wd = nb_reg;
                end else begin
                    nx_wd = blk_reg;
                end
                pos_next   = curr_reg;
                state_next = S_DONE;
            end
            // Hand the result to the output register once it has room.
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pay_next    = res_pay_reg;
                    m_grant_next  = res_grant_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A pool size write restarts the list.
        if (cfg_valid) begin
            if (cfg_ext < CLAMP_W'(2)) begin
                pool_next = PU_W'(2);
            end else if (cfg_ext > CLAMP_W'(POOL_DEPTH)) begin
                pool_next = PU_W'(POOL_DEPTH);
            end else begin
                pool_next = PU_W'(cfg_ext);
            end
            state_next = S_CLEAR;
            clr_next   = '0;
            pos_next   = '0;
            empty_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg       <= need_next;
        blk_reg        <= blk_next;
        start_reg      <= start_next;
        prev_reg       <= prev_next;
        curr_reg       <= curr_next;
        cnt_reg        <= cnt_next;
        nxt_reg        <= nxt_next;
        tail_reg       <= tail_next;
        next_n_reg     <= next_n_next;
        nb_reg         <= nb_next;
        size_b_reg     <= size_b_next;
        size_n_reg     <= size_n_next;
        size_c_reg     <= size_c_next;
        sb2_reg        <= sb2_next;
        res_status_reg <= res_status_next;
        res_pay_reg    <= res_pay_next;
        res_grant_reg  <= res_grant_next;
        m_status_reg   <= m_status_next;
        m_pay_reg      <= m_pay_next;
        m_grant_reg    <= m_grant_next;
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pool_reg    <= PU_W'((POOL_DEPTH < 4096) ? POOL_DEPTH : 4096);
            pos_reg     <= '0;
            empty_reg   <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pool_reg    <= pool_next;
            pos_reg     <= pos_next;
            empty_reg   <= empty_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The front part holds off while the sweep runs.
    assign status.clearing   = (state_reg == S_CLEAR);
    assign status.pool_units = MAX_PU_W'(pool_reg);
    assign cfg_ready         = 1'b1;
    assign m_tvalid          = m_valid_reg;
    assign m_tdata           = {(32 - INDEX_W - GRANT_W)'(0), m_grant_reg, m_pay_reg};
    assign m_tuser           = m_status_reg;
endmodule
`default_nettype wire

[test/tb_first_fit_free_list_allocator_top.sv]
// Self-checking testbench for the first-fit free-list allocator top level.
`default_nettype none
module tb_first_fit_free_list_allocator_top;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_POOL_DEPTH;
    localparam int UBYTES = DEF_UNIT_BYTES;
    localparam int MAX_REQ = 32760;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;   // pool_units[12:0]
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;    // request_bytes[14:0], block_index[26:15]
    logic [0:0]         s_tuser;    // command[0]
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;    // payload_index[11:0], granted_units[24:12]
    logic [0:0]         m_tuser;    // status[0]

    first_fit_free_list_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // One expected grant as it should leave the block.
    typedef struct {
        logic                status;
        logic [INDEX_W-1:0]  payload;
        logic [GRANT_W-1:0]  granted;
    } grant_t;

    grant_t pending_grants[$];
    int     live_blocks[$];
    int     error_count = 0;
    bit     idle_on = 1'b1;
    int     hold_cycles = 0;

    // Shadow copy of the free list.
    int blk_next[DEPTH];
    int blk_size[DEPTH];
    int scan_pos;
    bit list_is_empty;
    int pool_units;

    // Rebuilds the shadow list as one free block of the given size.
    function automatic void reset_pool(int units);
        pool_units = units < 2 ? 2 : (units > DEPTH ? DEPTH : units);
        foreach (blk_next[i]) begin
            blk_next[i] = 0;
            blk_size[i] = 0;
        end
        blk_size[0] = pool_units;
        scan_pos = 0;
        list_is_empty = 1'b0;
    endfunction

    // First-fit walk starting after the remembered list position.
    function automatic grant_t predict_alloc(int req);
        grant_t g;
        int need, start, prev, curr, tail;
        need = (req + UBYTES - 1) / UBYTES + 1;
        g.status = STATUS_FAIL;
        g.payload = '0;
        g.granted = '0;
        if (list_is_empty) return g;
        start = scan_pos;
        prev = start;
        curr = blk_next[prev];
        for (int v = 0; v <= DEPTH; v++) begin
            if (blk_size[curr] >= need) begin
                if (blk_size[curr] == need) begin
                    if (prev == curr) begin
                        list_is_empty = 1'b1;
                    end else begin
                        blk_next[prev] = blk_next[curr];
                        scan_pos = prev;
                    end
                end else begin
                    // Split: the front is granted, the tail stays in the list.
                    tail = (curr + need) % DEPTH;
                    blk_next[tail] = blk_next[curr];
                    blk_size[tail] = blk_size[curr] - need;
                    blk_size[curr] = need;
                    if (prev == curr) prev = tail;
                    blk_next[prev] = tail;
                    scan_pos = prev;
                end
                g.status = STATUS_DONE;
                g.payload = INDEX_W'(curr + 1);
                g.granted = GRANT_W'(need);
                return g;
            end
            if (curr == start) break;
            prev = curr;
            curr = blk_next[curr];
        end
        return g;
    endfunction

    // Address-ordered insert with merging on both sides.
    function automatic void predict_free(int idx);
        int blk, curr, nxt;
        bit found;
        found = 1'b0;
        if (idx == 0 || idx - 1 >= pool_units) return;
        blk = idx - 1;
        if (list_is_empty) begin
            blk_next[blk] = blk;
            scan_pos = blk;
            list_is_empty = 1'b0;
            return;
        end
        curr = scan_pos;
        for (int s = 0; s < DEPTH; s++) begin
            nxt = blk_next[curr];
            if ((blk > curr && blk < nxt) || (curr >= nxt && (blk > curr || blk < nxt))) begin
                found = 1'b1;
                break;
            end
            curr = nxt;
        end
        if (!found) return;
        nxt = blk_next[curr];
        if (blk + blk_size[blk] == nxt) begin
            blk_size[blk] += blk_size[nxt];
            if (curr == nxt) begin
                blk_next[blk] = blk;
                scan_pos = blk;
                return;
            end
            blk_next[blk] = blk_next[nxt];
        end else begin
            blk_next[blk] = nxt;
        end
        if (curr + blk_size[curr] == blk) begin
            blk_size[curr] += blk_size[blk];
            blk_next[curr] = blk_next[blk];
        end else begin
            blk_next[curr] = blk;
        end
        scan_pos = curr;
    endfunction

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: long hold-offs on request, otherwise random stall bursts.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every result item with the oldest expected grant.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %h", m_tdata, m_tuser);
                error_count++;
            end else begin
                grant_t g;
                g = pending_grants.pop_front();
                if (m_tuser[0] !== g.status) begin
                    $error("status: expected %0d, actual %0d", g.status, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[11:0] !== g.payload) begin
                    $error("payload_index: expected %0d, actual %0d", g.payload, m_tdata[11:0]);
                    error_count++;
                end
                if (m_tdata[24:12] !== g.granted) begin
                    $error("granted_units: expected %0d, actual %0d", g.granted,
                           m_tdata[24:12]);
                    error_count++;
                end
                if (m_tdata[31:25] !== '0) begin
                    $error("tdata pad: expected 0, actual %0h", m_tdata[31:25]);
                    error_count++;
                end
            end
        end
    end

    // Sends one item and records the grant it should produce.
    task automatic send_item(logic cmd, int req, int idx);
        grant_t g;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, INDEX_W'(idx), REQ_W'(req)};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_ALLOC) begin
            g = predict_alloc(req);
            if (g.status == STATUS_DONE) live_blocks.push_back(int'(g.payload));
        end else begin
            predict_free(idx);
            g.status = STATUS_DONE;
            g.payload = '0;
            g.granted = '0;
        end
        pending_grants.push_back(g);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Writes the pool size once the block is idle.
    task automatic set_pool(int units);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(units);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reset_pool(units & 13'h1FFF);
        live_blocks.delete();
    endtask

    // Frees a random live block.
    task automatic free_live();
        int k;
        int idx;
        k = $urandom_range(0, live_blocks.size() - 1);
        idx = live_blocks[k];
        live_blocks.delete(k);
        send_item(CMD_FREE, $urandom_range(0, MAX_REQ), idx);
    endtask

    // One random command: mostly well-formed alloc/free traffic, some noise.
    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_item(CMD_FREE, $urandom_range(0, MAX_REQ), $urandom_range(0, 4095));
        end else if (r < 8) begin
            send_item(CMD_ALLOC, $urandom_range(0, MAX_REQ), $urandom_range(0, 4095));
        end else if (r < 50 && live_blocks.size() != 0) begin
            free_live();
        end else begin
            send_item(CMD_ALLOC, $urandom_range(0, pool_units * UBYTES / 4),
                      $urandom_range(0, 4095));
        end
    endtask

    // Field extremes and the list corner cases.
    task automatic test_directed();
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_ALLOC, MAX_REQ, 4095);
        send_item(CMD_ALLOC, 1, 0);
        send_item(CMD_ALLOC, 8, 0);
        send_item(CMD_ALLOC, 9, 0);
        send_item(CMD_FREE, 0, 0);
        send_item(CMD_FREE, 0, 4095);
        send_item(CMD_FREE, MAX_REQ, 2);
        send_item(CMD_FREE, 0, 2);
        send_item(CMD_FREE, 0, 1);
        send_item(CMD_ALLOC, 16, 0);
        // Smallest pool: empty list, free into empty list, merge into one node.
        set_pool(0);
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_FREE, 0, 1);
        send_item(CMD_FREE, 0, 2);
        send_item(CMD_ALLOC, 8, 0);
        send_item(CMD_FREE, 0, 1);
        send_item(CMD_FREE, 0, 3);
        send_item(CMD_ALLOC, 9, 0);
        set_pool(8191);
        send_item(CMD_ALLOC, MAX_REQ - 8, 0);
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_FREE, 0, 1);
    endtask

    // Receiver holds off while commands keep coming, so the input stalls.
    task automatic test_backpressure();
        set_pool(64);
        idle_on = 1'b0;
        hold_cycles = 400;
        repeat (20) random_command();
        idle_on = 1'b1;
    endtask

    // Random traffic over several pool sizes.
    task automatic test_random_pools();
        int sizes[5] = '{1, 40, 300, 4096, 17};
        foreach (sizes[i]) begin
            set_pool(sizes[i]);
            repeat (250) random_command();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_full_rate();
        set_pool(100);
        idle_on = 1'b0;
        repeat (400) random_command();
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        reset_pool(DEPTH);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_pools();
        test_full_rate();
        wait_drained();
        if (error_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_front.sv
sv/ffa_queue.sv
sv/ffa_back.sv
sv/first_fit_free_list_allocator_top.sv
test/tb_first_fit_free_list_allocator_top.sv
